>>> src/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Shared types and codes of the modular inverse block: datapath operations,
// result status codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int MI_WIDTH = 16;
	localparam int ST_W     = 2;

	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_NO_INVERSE  = 2'd1;
	localparam status_t ST_BAD_MODULUS = 2'd2;

	typedef logic [2:0] op_t;

	localparam op_t OP_NONE   = 3'd0;
	localparam op_t OP_LOAD   = 3'd1;
	localparam op_t OP_INIT   = 3'd2;
	localparam op_t OP_ALIGN  = 3'd3;
	localparam op_t OP_SUB    = 3'd4;
	localparam op_t OP_EUCLID = 3'd5;
	localparam op_t OP_SWAP   = 3'd6;

	typedef struct packed {
		op_t  op;
		logic load_out;
	} mi_cmd_t;

	typedef struct packed {
		logic m_zero;
		logic r1_zero;
		logic k_zero;
		logic can_shift;
	} mi_sts_t;

endpackage

>>> src/mi_dpath.sv
// ----------------------------------------------------------------------------
// mi_dpath
// Remainder and coefficient registers of the extended Euclid loop with a
// shift-subtract divider that accumulates q * s1 while it divides.
// ----------------------------------------------------------------------------
module mi_dpath
	import mi_pkg::*;
#(
	parameter int WIDTH = MI_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mi_cmd_t          cmd,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output mi_sts_t          sts,
	output logic [WIDTH-1:0] inverse,
	output status_t          status
);

	localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] r0_q;
	logic [WIDTH-1:0] r1_q;
	logic [WIDTH-1:0] s0_q;
	logic [WIDTH-1:0] s1_q;
	logic             neg0_q;
	logic             neg1_q;
	logic [WIDTH-1:0] dr_q;
	logic [WIDTH-1:0] ds_q;
	logic [KW-1:0]    k_q;
	logic [WIDTH-1:0] inverse_q;
	status_t          status_q;

	logic             sub_ge;
	logic [WIDTH-1:0] s_red;
	logic [WIDTH-1:0] inv_nxt;
	status_t          status_nxt;

	assign sub_ge = (r0_q >= dr_q);

	assign sts.m_zero    = (m_q == '0);
	assign sts.r1_zero   = (r1_q == '0);
	assign sts.k_zero    = (k_q == '0);
	assign sts.can_shift = ({dr_q, 1'b0} <= {1'b0, r0_q});

	// the coefficient magnitude never exceeds m, so one compare reduces it
	assign s_red = (s0_q == m_q) ? '0 : s0_q;

	always_comb begin
		inv_nxt    = '0;
		status_nxt = ST_OK;
		if (m_q == '0) begin
			status_nxt = ST_BAD_MODULUS;
		end else if (r0_q != WIDTH'(1)) begin
			status_nxt = ST_NO_INVERSE;
		end else if (neg0_q && (s_red != '0)) begin
			inv_nxt = m_q - s_red;
		end else begin
			inv_nxt = s_red;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				m_q  <= modulus;
				r0_q <= value;
				r1_q <= modulus;
				s0_q <= '0;
				s1_q <= '0;
			end
			OP_INIT: begin
				dr_q <= r1_q;
				ds_q <= s1_q;
				k_q  <= '0;
			end
			OP_ALIGN: begin
				dr_q <= {dr_q[WIDTH-2:0], 1'b0};
				ds_q <= {ds_q[WIDTH-2:0], 1'b0};
				k_q  <= k_q + KW'(1);
			end
			OP_SUB: begin
				if (sub_ge) begin
					r0_q <= r0_q - dr_q;
					s0_q <= s0_q + ds_q;
				end
				dr_q <= dr_q >> 1;
				ds_q <= ds_q >> 1;
				k_q  <= k_q - KW'(1);
			end
			OP_EUCLID: begin
				// value reduced: start the loop on (m, value mod m)
				r0_q   <= m_q;
				r1_q   <= r0_q;
				s0_q   <= '0;
				s1_q   <= WIDTH'(1);
				neg0_q <= 1'b0;
				neg1_q <= 1'b0;
			end
			OP_SWAP: begin
				r0_q   <= r1_q;
				r1_q   <= r0_q;
				s0_q   <= s1_q;
				s1_q   <= s0_q;
				neg0_q <= neg1_q;
				neg1_q <= ~neg1_q;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			inverse_q <= inv_nxt;
			status_q  <= status_nxt;
		end
	end

	assign inverse = inverse_q;
	assign status  = status_q;

	// partial remainder stays below twice the shifted divisor
	a_sub_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SUB) |-> ({1'b0, r0_q} < {dr_q, 1'b0}))
		else $error("partial remainder out of range for divisor step");

	// shifted coefficient never exceeds the modulus when it is added
	a_coef_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SUB) && sub_ge |-> (ds_q <= m_q))
		else $error("coefficient term exceeds modulus");

endmodule

>>> src/mi_ctrl.sv
// ----------------------------------------------------------------------------
// mi_ctrl
// Sequencer of the modular inverse: input transfer, reduction pass, Euclid
// steps built from align and subtract cycles, and the output register slot.
// ----------------------------------------------------------------------------
module mi_ctrl
	import mi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  mi_sts_t sts,
	output mi_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_ALIGN  = 3'd2;
	localparam logic [2:0] ST_SUB    = 3'd3;
	localparam logic [2:0] ST_NEXT   = 3'd4;
	localparam logic [2:0] ST_CHECK  = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       reduce_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       in_xfer;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt    = state_q;
		cmd.op       = OP_NONE;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				if (sts.m_zero) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.op    = OP_INIT;
					state_nxt = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (sts.can_shift) begin
					cmd.op = OP_ALIGN;
				end else begin
					state_nxt = ST_SUB;
				end
			end
			ST_SUB: begin
				cmd.op = OP_SUB;
				if (sts.k_zero) begin
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT: begin
				cmd.op    = reduce_q ? OP_EUCLID : OP_SWAP;
				state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.r1_zero) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.op    = OP_INIT;
					state_nxt = ST_ALIGN;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			reduce_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_xfer) begin
				reduce_q <= 1'b1;
			end else if (state_q == ST_NEXT) begin
				reduce_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_START) && reduce_q)
		else $error("accepted transfer did not start a reduction pass");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && slot_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished result not placed in output register");

	a_align_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALIGN) && !sts.can_shift |=> (state_q == ST_SUB))
		else $error("aligned divisor did not enter subtract phase");

	a_sub_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUB) && sts.k_zero |=> (state_q == ST_NEXT))
		else $error("last subtract step did not end the division");

endmodule

>>> src/modular_inverse.sv
// ----------------------------------------------------------------------------
// modular_inverse
// Inverse of value modulo modulus by the extended Euclidean algorithm, with
// the coefficient held as magnitude and sign. Status flags a missing inverse
// (gcd not one) and a zero modulus.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------
//   in      | in_valid/in_stall  | value, modulus
//   out     | out_valid/out_stall| inverse, status
//
// One item at a time. Each division pass (one for value mod modulus, then one
// per Euclid step) runs align, then subtract steps in the shift-subtract
// divider, then a swap (or the start of the Euclid loop) and a check; load
// and finish frame the run, whose length is set by the number of Euclid
// steps and the quotient sizes. A zero modulus goes from load to finish.
// Reset clears the sequencer and output valid; no clearing pass.
// The result waits in the output register under out_stall while the next
// transfer is already taken.
// ----------------------------------------------------------------------------
module modular_inverse
	import mi_pkg::*;
#(
	parameter int WIDTH = MI_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] modulus,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] inverse,
	output logic [ST_W-1:0]  status
);

	mi_cmd_t cmd;
	mi_sts_t sts;

	mi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mi_dpath #(
		.WIDTH (WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value   (value),
		.modulus (modulus),
		.sts     (sts),
		.inverse (inverse),
		.status  (status)
	);

endmodule
